FILE: sv/dtfb_pkg.sv
package dtfb_pkg;

  // slots shared between the front pipeline and the request queue
  localparam int unsigned QDEPTH = 4;

  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_TEST_WRITE = 3'd1,
    OP_READ_PIXEL = 3'd2,
    OP_READ_DEPTH = 3'd3,
    OP_FILL       = 3'd4,
    OP_CLEAR      = 3'd5,
    OP_NOP        = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    CMP_NEVER         = 3'd0,
    CMP_LESS          = 3'd1,
    CMP_EQUAL         = 3'd2,
    CMP_LESS_EQUAL    = 3'd3,
    CMP_GREATER       = 3'd4,
    CMP_NOT_EQUAL     = 3'd5,
    CMP_GREATER_EQUAL = 3'd6,
    CMP_ALWAYS        = 3'd7
  } cmp_mode_e;

  typedef enum logic [1:0] {
    B_BOOT,
    B_IDLE,
    B_EXEC,
    B_SWEEP
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] depth;
    logic [23:0]        colour;
  } cmd_t;

  function automatic logic signed [15:0] sat_q(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > Q_ONE) r = Q_ONE;
    if (v < -Q_ONE) r = -Q_ONE;
    return r;
  endfunction

  function automatic logic depth_pass(input cmp_mode_e mode,
                                      input logic signed [15:0] inc,
                                      input logic signed [15:0] st);
    logic p;
    unique case (mode)
      CMP_NEVER:         p = 1'b0;
      CMP_LESS:          p = inc < st;
      CMP_EQUAL:         p = inc == st;
      CMP_LESS_EQUAL:    p = inc <= st;
      CMP_GREATER:       p = inc > st;
      CMP_NOT_EQUAL:     p = inc != st;
      CMP_GREATER_EQUAL: p = inc >= st;
      CMP_ALWAYS:        p = 1'b1;
      default:           p = 1'b0;
    endcase
    return p;
  endfunction

endpackage

FILE: sv/dtfb_ram.sv
module dtfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/dtfb_front.sv
module dtfb_front
  import dtfb_pkg::*;
#(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [2:0]                             opcode_i,
  input  logic signed [15:0]                     x_pos_i,
  input  logic signed [15:0]                     y_pos_i,
  input  logic signed [15:0]                     depth_in_i,
  input  logic [7:0]                             red_in_i,
  input  logic [7:0]                             green_in_i,
  input  logic [7:0]                             blue_in_i,
  output logic                                   push_o,
  output cmd_t                                   push_cmd_o,
  output logic [$clog2(FB_WIDTH*FB_HEIGHT)-1:0]  push_addr_o,
  output logic [1:0]                             occupancy_o
);

  localparam int CW   = $clog2(FB_WIDTH);
  localparam int RW   = $clog2(FB_HEIGHT);
  localparam int AW   = $clog2(FB_WIDTH * FB_HEIGHT);
  localparam int PW_X = CW + 16;
  localparam int PW_Y = RW + 16;
  localparam logic [CW-1:0] W_M1 = CW'(FB_WIDTH - 1);
  localparam logic [RW-1:0] H_M1 = RW'(FB_HEIGHT - 1);

  // stage 1: saturate, classify, scale both axes
  logic signed [15:0] xs, ys;
  logic [15:0]        ux, uy;
  logic [PW_X-1:0]    prod_x;
  logic [PW_Y-1:0]    prod_y;
  cmd_t               cmd_d;

  logic               s1_valid_q;
  cmd_t               s1_cmd_q;
  logic [CW-1:0]      s1_col_q;
  logic [RW-1:0]      s1_r_q;

  logic               s2_valid_q;
  cmd_t               s2_cmd_q;
  logic [AW-1:0]      s2_addr_q;

  logic [RW-1:0]      row;
  logic [AW-1:0]      addr_d;

  always_comb begin
    xs = sat_q(x_pos_i);
    ys = sat_q(y_pos_i);
    ux = 16'(17'(xs) + 17'(Q_ONE));
    uy = 16'(17'(ys) + 17'(Q_ONE));
    prod_x = PW_X'(ux) * PW_X'(W_M1);
    prod_y = PW_Y'(uy) * PW_Y'(H_M1);
    cmd_d.op     = (opcode_i <= 3'(OP_CLEAR)) ? op_e'(opcode_i) : OP_NOP;
    cmd_d.depth  = sat_q(depth_in_i);
    cmd_d.colour = {red_in_i, green_in_i, blue_in_i};
  end

  // stage 2: flip the row (row 0 is the top) and form the linear address
  assign row    = H_M1 - s1_r_q;
  assign addr_d = AW'(AW'(row) * AW'(FB_WIDTH)) + AW'(s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= cmd_d;
    s1_col_q  <= prod_x[PW_X-2:15];
    s1_r_q    <= prod_y[PW_Y-2:15];
    s2_cmd_q  <= s1_cmd_q;
    s2_addr_q <= addr_d;
  end

  // a queue slot is reserved at acceptance, so stage 2 always pushes
  assign push_o      = s2_valid_q;
  assign push_cmd_o  = s2_cmd_q;
  assign push_addr_o = s2_addr_q;
  assign occupancy_o = 2'(s1_valid_q) + 2'(s2_valid_q);

endmodule

FILE: sv/dtfb_queue.sv
module dtfb_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [DW-1:0]              push_data_i,
  input  logic                       pop_i,
  output logic [DW-1:0]              head_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNW = $clog2(DEPTH + 1);

  logic [DW-1:0]  slot_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNW'(push_i) - CNW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

FILE: sv/dtfb_back.sv
module dtfb_back
  import dtfb_pkg::*;
#(
  parameter int PIXELS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmp_mode_e                 cmp_mode_i,
  input  logic                      q_empty_i,
  input  cmd_t                      q_cmd_i,
  input  logic [$clog2(PIXELS)-1:0] q_addr_i,
  output logic                      q_pop_o,
  output logic                      valid_o,
  output logic [7:0]                red_out_o,
  output logic [7:0]                green_out_o,
  output logic [7:0]                blue_out_o,
  output logic signed [15:0]        depth_out_o,
  output logic                      test_passed_o
);

  localparam int AW = $clog2(PIXELS);

  back_state_e        state_q, state_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  cmd_t               cur_q, cur_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               last;

  logic               c_we, d_we;
  logic [AW-1:0]      waddr;
  logic [23:0]        c_wdata, c_rdata;
  logic [15:0]        d_wdata, d_rdata;
  logic signed [15:0] stored_depth;
  logic               pass;

  logic               valid_q, valid_d;
  logic [23:0]        colour_q, colour_d;
  logic signed [15:0] depth_q, depth_d;
  logic               passed_q, passed_d;

  assign last         = (cnt_q == AW'(PIXELS - 1));
  assign stored_depth = d_rdata;
  assign pass         = depth_pass(cmp_mode_i, cur_q.depth, stored_depth);

  // read port always follows the queue head; data is ready in B_EXEC
  dtfb_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_colour_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (waddr),
    .wdata_i (c_wdata),
    .raddr_i (q_addr_i),
    .rdata_o (c_rdata)
  );

  dtfb_ram #(.WIDTH(16), .DEPTH(PIXELS)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (waddr),
    .wdata_i (d_wdata),
    .raddr_i (q_addr_i),
    .rdata_o (d_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_BOOT: begin
        if (last) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          unique case (q_cmd_i.op) inside
            OP_FILL, OP_CLEAR: state_d = B_SWEEP;
            OP_NOP:            state_d = B_IDLE;
            default:           state_d = B_EXEC;
          endcase
        end
      end
      B_EXEC: begin
        state_d = B_IDLE;
      end
      B_SWEEP: begin
        if (last) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    c_we     = 1'b0;
    d_we     = 1'b0;
    waddr    = addr_q;
    c_wdata  = cur_q.colour;
    d_wdata  = cur_q.depth;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    addr_d   = addr_q;
    valid_d  = 1'b0;
    colour_d = '0;
    depth_d  = '0;
    passed_d = 1'b0;
    unique case (state_q)
      B_BOOT: begin
        waddr   = cnt_q;
        c_we    = 1'b1;
        d_we    = 1'b1;
        c_wdata = '0;
        d_wdata = Q_ONE;
        cnt_d   = cnt_q + 1'b1;
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_cmd_i;
          addr_d  = q_addr_i;
          cnt_d   = '0;
          if (q_cmd_i.op == OP_NOP) valid_d = 1'b1;
        end
      end
      B_EXEC: begin
        valid_d  = 1'b1;
        colour_d = c_rdata;
        depth_d  = stored_depth;
        case (cur_q.op)
          OP_WRITE: begin
            c_we     = 1'b1;
            colour_d = cur_q.colour;
          end
          OP_TEST_WRITE: begin
            if (pass) begin
              c_we     = 1'b1;
              d_we     = 1'b1;
              colour_d = cur_q.colour;
              depth_d  = cur_q.depth;
              passed_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      B_SWEEP: begin
        waddr = cnt_q;
        c_we  = 1'b1;
        if (cur_q.op == OP_CLEAR) begin
          c_wdata = '0;
          d_wdata = Q_ONE;
          d_we    = 1'b1;
        end
        cnt_d = cnt_q + 1'b1;
        if (last) valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_BOOT;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    addr_q   <= addr_d;
    colour_q <= colour_d;
    depth_q  <= depth_d;
    passed_q <= passed_d;
  end

  assign valid_o       = valid_q;
  assign red_out_o     = colour_q[23:16];
  assign green_out_o   = colour_q[15:8];
  assign blue_out_o    = colour_q[7:0];
  assign depth_out_o   = depth_q;
  assign test_passed_o = passed_q;

endmodule

FILE: sv/depth_tested_frame_buffer.sv
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------------
// request  | start_i, busy_o        | opcode_i, x/y_pos_i, depth_in_i, rgb _in_i
// result   | valid_o (1-cycle pulse)| red/green/blue_out_o, depth_out_o,
//          |                        | test_passed_o
// config   | cfg_we_i               | cfg_wdata_i (depth compare mode)
//
// Pixel ops in the back end do the memory read in B_IDLE, then write and result in B_EXEC;
// the front pipeline scales the address and a 4-entry queue sits between.
// Fill and clear sweep all FB_WIDTH*FB_HEIGHT memory locations.
// After reset the back end clears both stores at every address;
// up to 4 requests are taken meanwhile. busy_o rises once 4 requests are
// pending. Results cannot be stalled: valid_o marks each for one cycle.
module depth_tested_frame_buffer
  import dtfb_pkg::*;
#(
  parameter int FB_WIDTH  = 64,
  parameter int FB_HEIGHT = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic [2:0]         opcode_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic signed [15:0] depth_in_i,
  input  logic [7:0]         red_in_i,
  input  logic [7:0]         green_in_i,
  input  logic [7:0]         blue_in_i,
  output logic               valid_o,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  output logic signed [15:0] depth_out_o,
  output logic               test_passed_o
);

  localparam int PIXELS = FB_WIDTH * FB_HEIGHT;
  localparam int AW     = $clog2(PIXELS);
  localparam int QDW    = $bits(cmd_t) + AW;
  localparam int CNW    = $clog2(QDEPTH + 1);

  cmp_mode_e         mode_q;
  logic              accept;
  logic              push;
  cmd_t              push_cmd;
  logic [AW-1:0]     push_addr;
  logic [1:0]        front_occ;
  logic [QDW-1:0]    head;
  logic              q_empty, q_pop;
  logic [CNW-1:0]    q_count;
  cmd_t              head_cmd;
  logic [AW-1:0]     head_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= CMP_LESS;
    end else if (cfg_we_i) begin
      mode_q <= cmp_mode_e'(cfg_wdata_i);
    end
  end

  // requests in the front pipeline already hold a queue slot
  assign busy_o = (4'(front_occ) + 4'(q_count)) >= 4'(QDEPTH);
  assign accept = start_i && !busy_o;

  dtfb_front #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .opcode_i    (opcode_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .depth_in_i  (depth_in_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .push_addr_o (push_addr),
    .occupancy_o (front_occ)
  );

  dtfb_queue #(.DW(QDW), .DEPTH(QDEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_cmd, push_addr}),
    .pop_i       (q_pop),
    .head_o      (head),
    .empty_o     (q_empty),
    .count_o     (q_count)
  );

  assign head_cmd  = head[QDW-1:AW];
  assign head_addr = head[AW-1:0];

  dtfb_back #(.PIXELS(PIXELS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmp_mode_i    (mode_q),
    .q_empty_i     (q_empty),
    .q_cmd_i       (head_cmd),
    .q_addr_i      (head_addr),
    .q_pop_o       (q_pop),
    .valid_o       (valid_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .depth_out_o   (depth_out_o),
    .test_passed_o (test_passed_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dtfb_pkg::*;

  localparam int FB_W = 64;
  localparam int FB_H = 64;
  localparam int PIXELS = FB_W * FB_H;
  // opcode seven has no name in the package; it must behave as a no-op
  localparam logic [2:0] OP_SPARE = 3'd7;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic signed [15:0] depth;
    logic               passed;
  } pixel_result_t;

  function automatic logic signed [15:0] clamp_q14(input logic signed [15:0] v);
    int s;
    s = int'(v);
    if (s > 16384) s = 16384;
    else if (s < -16384) s = -16384;
    return 16'(s);
  endfunction

  // normalised coordinate to pixel index along one axis
  function automatic int unsigned axis_index(input logic signed [15:0] q,
                                             input int unsigned size);
    int unsigned u;
    u = int'(q) + 16384;
    return (u * (size - 1)) / 32768;
  endfunction

  class frame_scoreboard;
    logic [23:0]        colour_mem [PIXELS];
    logic signed [15:0] depth_mem  [PIXELS];
    cmp_mode_e          mode;
    pixel_result_t      expected_pixels [$];
    int unsigned        mismatches;
    int unsigned        results_checked;
    int unsigned        requests_noted;
    int unsigned        tests_passed;
    int unsigned        sweeps;

    function new();
      clear_stores();
      mode = CMP_LESS;
      mismatches = 0;
      results_checked = 0;
      requests_noted = 0;
      tests_passed = 0;
      sweeps = 0;
    endfunction

    function void clear_stores();
      foreach (colour_mem[i]) begin
        colour_mem[i] = '0;
        depth_mem[i] = 16'sd16384;
      end
    endfunction

    function bit depth_test_ok(input logic signed [15:0] inc,
                               input logic signed [15:0] st);
      case (mode)
        CMP_NEVER:         return 1'b0;
        CMP_LESS:          return inc < st;
        CMP_EQUAL:         return inc == st;
        CMP_LESS_EQUAL:    return inc <= st;
        CMP_GREATER:       return inc > st;
        CMP_NOT_EQUAL:     return inc != st;
        CMP_GREATER_EQUAL: return inc >= st;
        default:           return 1'b1;
      endcase
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    function void note_request(input logic [2:0] op, input logic signed [15:0] x,
                               input logic signed [15:0] y, input logic signed [15:0] z,
                               input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b);
      pixel_result_t res;
      logic signed [15:0] zq;
      int unsigned addr;
      bit pixel_op;
      res = '0;
      pixel_op = 1'b1;
      zq = clamp_q14(z);
      addr = (FB_H - 1 - axis_index(clamp_q14(y), FB_H)) * FB_W
             + axis_index(clamp_q14(x), FB_W);
      if (addr >= PIXELS) addr = PIXELS - 1;
      requests_noted++;
      case (op) inside
        OP_WRITE: colour_mem[addr] = {r, g, b};
        OP_TEST_WRITE: begin
          if (depth_test_ok(zq, depth_mem[addr])) begin
            depth_mem[addr] = zq;
            colour_mem[addr] = {r, g, b};
            res.passed = 1'b1;
            tests_passed++;
          end
        end
        OP_READ_PIXEL, OP_READ_DEPTH: ;
        OP_FILL: begin
          foreach (colour_mem[i]) colour_mem[i] = {r, g, b};
          pixel_op = 1'b0;
          sweeps++;
        end
        OP_CLEAR: begin
          clear_stores();
          pixel_op = 1'b0;
          sweeps++;
        end
        default: pixel_op = 1'b0;
      endcase
      if (pixel_op) begin
        {res.red, res.green, res.blue} = colour_mem[addr];
        res.depth = depth_mem[addr];
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_result(input pixel_result_t got);
      pixel_result_t exp;
      results_checked++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result r=%0h g=%0h b=%0h z=%0d pass=%0b", $realtime,
                   got.red, got.green, got.blue, got.depth, got.passed);
        return;
      end
      exp = expected_pixels.pop_front();
      if (got.red !== exp.red || got.green !== exp.green || got.blue !== exp.blue ||
          got.depth !== exp.depth || got.passed !== exp.passed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: exp r=%0h g=%0h b=%0h z=%0d pass=%0b, got r=%0h g=%0h b=%0h z=%0d pass=%0b",
                   $realtime, exp.red, exp.green, exp.blue, exp.depth, exp.passed,
                   got.red, got.green, got.blue, got.depth, got.passed);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_wdata_i = CMP_LESS;
  logic [2:0]         opcode_i = OP_READ_PIXEL;
  logic signed [15:0] x_pos_i = '0;
  logic signed [15:0] y_pos_i = '0;
  logic signed [15:0] depth_in_i = '0;
  logic [7:0]         red_in_i = '0;
  logic [7:0]         green_in_i = '0;
  logic [7:0]         blue_in_i = '0;
  logic               valid_o;
  logic [7:0]         red_out_o;
  logic [7:0]         green_out_o;
  logic [7:0]         blue_out_o;
  logic signed [15:0] depth_out_o;
  logic               test_passed_o;

  frame_scoreboard sb = new();
  int unsigned     sender_idle_pct = 0;

  // a few recurring positions and depths so requests keep landing on the same pixels
  logic signed [15:0] hot_pos   [4] = '{-16'sd16384, -16'sd3000, 16'sd7000, 16'sd16384};
  logic signed [15:0] hot_depth [5] = '{-16'sd16384, -16'sd4096, 16'sd0, 16'sd4096,
                                        16'sd16384};

  depth_tested_frame_buffer #(
    .FB_WIDTH (FB_W),
    .FB_HEIGHT(FB_H)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .opcode_i     (opcode_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .depth_in_i   (depth_in_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .valid_o      (valid_o),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .depth_out_o  (depth_out_o),
    .test_passed_o(test_passed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      sb.check_result('{red_out_o, green_out_o, blue_out_o, depth_out_o, test_passed_o});
  end

  task automatic send_request(input logic [2:0] op, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    opcode_i   <= op;
    x_pos_i    <= x;
    y_pos_i    <= y;
    depth_in_i <= z;
    red_in_i   <= r;
    green_in_i <= g;
    blue_in_i  <= b;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(op, x, y, z, r, g, b);
  endtask

  function automatic logic signed [15:0] pick_pos();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return hot_pos[$urandom_range(0, 3)];
    if (sel < 80) return 16'($urandom_range(0, 32768) - 16384);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_depth();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return hot_depth[$urandom_range(0, 4)];
    if (sel < 80) return 16'($urandom_range(0, 32768) - 16384);
    return 16'($urandom);
  endfunction

  task automatic send_random_request();
    int unsigned sel;
    logic [2:0]  op;
    sel = $urandom_range(0, 99);
    if (sel < 20)      op = OP_WRITE;
    else if (sel < 58) op = OP_TEST_WRITE;
    else if (sel < 73) op = OP_READ_PIXEL;
    else if (sel < 88) op = OP_READ_DEPTH;
    else if (sel < 91) op = OP_FILL;
    else if (sel < 93) op = OP_CLEAR;
    else if (sel < 96) op = OP_NOP;
    else               op = OP_SPARE;
    send_request(op, pick_pos(), pick_pos(), pick_depth(),
                 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // the register may only change once every request has produced its result
  task automatic wait_drained();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_compare_mode(input cmp_mode_e m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.mode = m;
  endtask

  initial begin
    #100_000_000;
    $display("depth_tested_frame_buffer regression: fail");
    $finish;
  end

  initial begin
    cmp_mode_e   phase_modes [8];
    int unsigned idle_plan [3];
    phase_modes = '{CMP_ALWAYS, CMP_NEVER, CMP_EQUAL, CMP_GREATER,
                    CMP_LESS_EQUAL, CMP_NOT_EQUAL, CMP_GREATER_EQUAL, CMP_LESS};
    idle_plan = '{0, 74, 29};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_compare_mode(CMP_LESS);

    // directed: corners, saturation, each opcode, pass and fail of the depth test
    send_request(OP_READ_PIXEL, -16'sd16384, -16'sd16384, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ_DEPTH, 16'sd16384, 16'sd16384, 16'sd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_WRITE, -16'sd16384, 16'sd16384, 16'sd0, 8'hff, 8'h00, 8'haa);
    send_request(OP_READ_PIXEL, -16'sd16384, 16'sd16384, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_TEST_WRITE, 16'sd0, 16'sd0, -16'sd16384, 8'h11, 8'h22, 8'h33);
    send_request(OP_TEST_WRITE, 16'sd0, 16'sd0, -16'sd16384, 8'h44, 8'h55, 8'h66);
    send_request(OP_TEST_WRITE, 16'sd8192, -16'sd8192, 16'sd16384, 8'h77, 8'h88, 8'h99);
    send_request(OP_TEST_WRITE, 16'sh7fff, 16'sh8000, 16'sh7fff, 8'hff, 8'hff, 8'hff);
    send_request(OP_TEST_WRITE, 16'sh8000, 16'sh7fff, 16'sh8000, 8'h5a, 8'ha5, 8'h3c);
    send_request(OP_READ_DEPTH, 16'sh8000, 16'sh7fff, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_WRITE, 16'sd16383, -16'sd16383, 16'sd0, 8'h01, 8'h80, 8'hfe);
    send_request(OP_READ_PIXEL, 16'sd16383, -16'sd16383, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_FILL, 16'sd0, 16'sd0, 16'sd0, 8'h12, 8'h34, 8'h56);
    send_request(OP_READ_PIXEL, 16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ_DEPTH, 16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_CLEAR, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff, 8'hff, 8'hff);
    send_request(OP_READ_DEPTH, 16'sd0, 16'sd0, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ_PIXEL, -16'sd16384, 16'sd16384, 16'sd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_NOP, 16'sd100, 16'sd100, 16'sd100, 8'hff, 8'hff, 8'hff);
    send_request(OP_SPARE, -16'sd1, -16'sd1, -16'sd1, 8'hff, 8'hff, 8'hff);
    send_request(OP_TEST_WRITE, -16'sd1, -16'sd1, 16'sd16383, 8'hc3, 8'h3c, 8'h00);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      sender_idle_pct = idle_plan[p % 3];
      set_compare_mode(phase_modes[p]);
      repeat (54) send_random_request();
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests over all eight compare modes and three idle levels",
             sb.requests_noted);
    $display("%0d results checked, %0d depth tests passed, %0d sweeps, %0d mismatches",
             sb.results_checked, sb.tests_passed, sb.sweeps, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("depth_tested_frame_buffer regression: pass");
    end else begin
      $display("depth_tested_frame_buffer regression: fail");
    end
    $finish;
  end

endmodule
